// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/gpti_pkg.sv
// ----------------------------------------------------------------------------
// gpti_pkg
// Types and constants of the grid potential interpolator.
// ----------------------------------------------------------------------------
package gpti_pkg;

	localparam int GRID_DEPTH_DEF = 262144;
	localparam int MAX_DIM_DEF    = 64;

	localparam int SIZE_W   = 7;
	localparam int IDXIN_W  = 18;
	localparam int VAL_W    = 32;
	localparam int FRAC_W   = 16;
	localparam int G_W      = 49;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 66;
	localparam int ACC_W    = 50;
	localparam int RAD_W    = 48;
	localparam int ROOT_W   = 24;
	localparam int ADR_W    = 22;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;
	localparam logic [1:0] REG_INV    = 2'd3;

	localparam logic [SIZE_W-1:0] SIZE_RST = 7'd1;
	localparam logic [31:0]       INV_RST  = 32'd655360;

	typedef struct packed {
		logic                    req_type;
		logic [IDXIN_W-1:0]      node_index;
		logic signed [VAL_W-1:0] node_value;
		logic signed [VAL_W-1:0] pos_x;
		logic signed [VAL_W-1:0] pos_y;
		logic signed [VAL_W-1:0] pos_z;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] potential;
		logic                    outside;
	} rsp_t;

endpackage

// File: rtl/gpti_sqrt.sv
// ----------------------------------------------------------------------------
// gpti_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gpti_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gpti_pkg::RAD_W-1:0]   radicand,
	output logic                         done,
	output logic [gpti_pkg::ROOT_W-1:0]  root
);

	localparam int RW  = gpti_pkg::ROOT_W;
	localparam int CW  = $clog2(RW + 1);

	logic [gpti_pkg::RAD_W-1:0] rad_q;
	logic [RW:0]                rem_q;
	logic [RW-1:0]              root_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [RW+2:0]              rem_sh;
	logic [RW+2:0]              trial;
	logic [RW+2:0]              rem_nx;
	logic                       ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[gpti_pkg::RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CW'(RW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= rad_q << 2;
				rem_q  <= rem_nx[RW:0];
				root_q <= {root_q[RW-2:0], ge};
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/grid_potential_trilinear_interp_top.sv
// ----------------------------------------------------------------------------
// grid_potential_trilinear_interp_top
// Potential grid store with trilinear or cylindrical bilinear interpolation.
// ----------------------------------------------------------------------------
// A load beat writes one grid node. A query beat takes longer in cylindrical
// mode and less when the point is outside or the grid is degenerate. Its
// time is set by the one shared 33x33 multiplier that forms grid coordinates,
// the squares for the radius in cylindrical mode, node addresses and all
// seven interpolation steps, two products per step, by the eight reads of the
// single-port grid memory, and in cylindrical mode by the square root.
// The block takes no new beat while a query is in work; a finished result
// waits in the output register while the next beat may enter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_potential_trilinear_interp_top #(
	parameter int GRID_DEPTH = gpti_pkg::GRID_DEPTH_DEF,
	parameter int MAX_DIM    = gpti_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gpti_pkg::PADDR_W-1:0]   paddr,
	input  logic [gpti_pkg::PDATA_W-1:0]   pwdata,
	output logic [gpti_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  gpti_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output gpti_pkg::rsp_t                 rsp
);

	localparam int SW     = gpti_pkg::SIZE_W;
	localparam int GW     = gpti_pkg::G_W;
	localparam int MW     = gpti_pkg::MUL_W;
	localparam int PW     = gpti_pkg::PROD_W;
	localparam int AW     = gpti_pkg::ACC_W;
	localparam int DW     = gpti_pkg::ADR_W;
	localparam int VW     = gpti_pkg::VAL_W;
	localparam int FW     = gpti_pkg::FRAC_W;
	localparam int RW     = gpti_pkg::ROOT_W;
	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int MEM_AW = $clog2(GRID_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE, S_GX, S_GY, S_GZ, S_GZW, S_MODE, S_UU, S_VV, S_SUM, S_SQS, S_SQ,
		S_AD0, S_AD1, S_AD2, S_AD3, S_RD, S_LA, S_LB, S_LC, S_DONE
	} state_t;

	state_t state_q;

	logic [SW-1:0] size_x_q, size_y_q, size_z_q;
	logic [31:0]   inv_q;
	logic          cfg_we;

	logic signed [VW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [GW-1:0] gx_q, gy_q, gz_q;
	logic signed [MW-1:0] u_q, v_q;
	logic [IDX_W-1:0]     i_q, j_q, k_q;
	logic [FW-1:0]        fx_q, fy_q, fz_q;
	logic                 cyl_q;
	logic [DW-1:0]        nxny_q, row_q, base_q;
	logic [3:0]           cnt_q;
	logic [2:0]           step_q;
	logic                 rdv_q, oob_q;
	logic signed [VW-1:0] w_q [8];
	logic signed [AW-1:0] acc_q;
	logic signed [PW-1:0] prod_q;
	logic signed [VW-1:0] pot_q;
	logic                 outs_q;
	logic                 out_valid_q;
	gpti_pkg::rsp_t       out_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic                 sq_start, sq_done;
	logic [RW-1:0]        sq_root;

	logic [VW-1:0]        mem [GRID_DEPTH];
	logic [VW-1:0]        rdata_q;
	logic                 mem_we, mem_re;
	logic [MEM_AW-1:0]    mem_addr;
	logic [31:0]          ld_full, rd_full;
	logic                 ld_ok;
	logic [DW-1:0]        rd_addr;

	logic                 degen, cyl, out_x, out_y, out_z, cyl_in, r_in;
	logic signed [GW-1:0] lim_x, lim_y, lim_z, u_g, v_g, root_g;
	logic [FW-1:0]        frac;
	logic [FW:0]          omf;
	logic signed [AW-1:0] lerp_sum;
	logic signed [VW-1:0] lerp_res;
	logic                 acc_q_in;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= gpti_pkg::SIZE_RST;
			size_y_q <= gpti_pkg::SIZE_RST;
			size_z_q <= gpti_pkg::SIZE_RST;
			inv_q    <= gpti_pkg::INV_RST;
		end else if (cfg_we) begin
			case (paddr[gpti_pkg::PADDR_W-1:2])
				gpti_pkg::REG_SIZE_X: size_x_q <= pwdata[SW-1:0];
				gpti_pkg::REG_SIZE_Y: size_y_q <= pwdata[SW-1:0];
				gpti_pkg::REG_SIZE_Z: size_z_q <= pwdata[SW-1:0];
				gpti_pkg::REG_INV:    inv_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[gpti_pkg::PADDR_W-1:2])
			gpti_pkg::REG_SIZE_X: prdata = {{(32-SW){1'b0}}, size_x_q};
			gpti_pkg::REG_SIZE_Y: prdata = {{(32-SW){1'b0}}, size_y_q};
			gpti_pkg::REG_SIZE_Z: prdata = {{(32-SW){1'b0}}, size_z_q};
			gpti_pkg::REG_INV:    prdata = inv_q;
			default:              prdata = '0;
		endcase
	end

	// mode and range decode
	always_comb begin
		lim_x  = $signed({{(GW-SW){1'b0}}, size_x_q}) - GW'(1);
		lim_y  = $signed({{(GW-SW){1'b0}}, size_y_q}) - GW'(1);
		lim_z  = $signed({{(GW-SW){1'b0}}, size_z_q}) - GW'(1);
		lim_x  = lim_x <<< FW;
		lim_y  = lim_y <<< FW;
		lim_z  = lim_z <<< FW;
		degen  = (32'(size_x_q) > 32'(MAX_DIM)) || (32'(size_y_q) > 32'(MAX_DIM)) ||
			(32'(size_z_q) > 32'(MAX_DIM)) ||
			!((size_x_q > SW'(2)) || (size_y_q > SW'(2)) || (size_z_q > SW'(2)));
		cyl    = (size_x_q > SW'(2)) && (size_y_q == SW'(1)) && (size_z_q > SW'(2));
		out_x  = (gx_q < 0) || (gx_q >= lim_x);
		out_y  = (gy_q < 0) || (gy_q >= lim_y);
		out_z  = (gz_q < 0) || (gz_q >= lim_z);
		u_g    = gx_q - lim_x;
		v_g    = gy_q - lim_x;
		cyl_in = (u_g > -lim_x) && (u_g < lim_x) && (v_g > -lim_x) && (v_g < lim_x) && !out_z;
		root_g = $signed({{(GW-RW){1'b0}}, sq_root});
		r_in   = root_g < lim_x;
	end

	// shared multiplier operands
	always_comb begin
		if (step_q < 3'd4) begin
			frac = fx_q;
		end else if (step_q < 3'd6) begin
			frac = fy_q;
		end else begin
			frac = fz_q;
		end
		omf = {1'b1, {FW{1'b0}}} - {1'b0, frac};
		case (state_q)
			S_GX: begin
				mul_a = $signed({pos_x_q[VW-1], pos_x_q});
				mul_b = $signed({1'b0, inv_q});
			end
			S_GY: begin
				mul_a = $signed({pos_y_q[VW-1], pos_y_q});
				mul_b = $signed({1'b0, inv_q});
			end
			S_GZ: begin
				mul_a = $signed({pos_z_q[VW-1], pos_z_q});
				mul_b = $signed({1'b0, inv_q});
			end
			S_UU: begin
				mul_a = u_q;
				mul_b = u_q;
			end
			S_VV: begin
				mul_a = v_q;
				mul_b = v_q;
			end
			S_AD0: begin
				mul_a = $signed({{(MW-SW){1'b0}}, size_x_q});
				mul_b = $signed({{(MW-SW){1'b0}}, size_y_q});
			end
			S_AD1: begin
				mul_a = $signed({{(MW-SW){1'b0}}, size_x_q});
				mul_b = $signed({{(MW-IDX_W){1'b0}}, j_q});
			end
			S_AD2: begin
				mul_a = $signed({{(MW-DW){1'b0}}, nxny_q});
				mul_b = $signed({{(MW-IDX_W){1'b0}}, k_q});
			end
			S_LA: begin
				mul_a = $signed({w_q[0][VW-1], w_q[0]});
				mul_b = $signed({{(MW-FW-1){1'b0}}, omf});
			end
			S_LB: begin
				mul_a = $signed({w_q[1][VW-1], w_q[1]});
				mul_b = $signed({{(MW-FW){1'b0}}, frac});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// grid memory
	assign ld_full  = {{(32-gpti_pkg::IDXIN_W){1'b0}}, req.node_index};
	assign ld_ok    = ld_full < 32'(GRID_DEPTH);
	assign rd_addr  = base_q + DW'(cnt_q[0]) +
		((cnt_q[1] && !cyl_q) ? DW'(size_x_q) : '0) + (cnt_q[2] ? nxny_q : '0);
	assign rd_full  = {{(32-DW){1'b0}}, rd_addr};
	assign mem_we   = req_valid && req_ready && (req.req_type == gpti_pkg::REQ_LOAD) && ld_ok;
	assign mem_re   = (state_q == S_RD) && !cnt_q[3];
	assign mem_addr = (state_q == S_IDLE) ? ld_full[MEM_AW-1:0] : rd_full[MEM_AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= req.node_value;
		end else if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// interpolation step
	assign acc_q_in = 1'b0;
	always_comb begin
		lerp_sum = acc_q + prod_q[AW-1:0] + AW'(32768);
		lerp_res = lerp_sum[FW +: VW];
	end

	assign sq_start = (state_q == S_SQS);

	gpti_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q[gpti_pkg::RAD_W-1:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			gx_q        <= '0;
			gy_q        <= '0;
			gz_q        <= '0;
			u_q         <= '0;
			v_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			fx_q        <= '0;
			fy_q        <= '0;
			fz_q        <= '0;
			cyl_q       <= 1'b0;
			nxny_q      <= '0;
			row_q       <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			rdv_q       <= 1'b0;
			oob_q       <= 1'b0;
			acc_q       <= '0;
			pot_q       <= '0;
			outs_q      <= 1'b0;
			for (int n = 0; n < 8; n++) begin
				w_q[n] <= '0;
			end
		end else begin
			if (rsp_valid && rsp_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req.req_type == gpti_pkg::REQ_QUERY) begin
						pos_x_q <= req.pos_x;
						pos_y_q <= req.pos_y;
						pos_z_q <= req.pos_z;
						state_q <= S_GX;
					end
				end
				S_GX: state_q <= S_GY;
				S_GY: begin
					gx_q    <= prod_q[FW +: GW];
					state_q <= S_GZ;
				end
				S_GZ: begin
					gy_q    <= prod_q[FW +: GW];
					state_q <= S_GZW;
				end
				S_GZW: begin
					gz_q    <= prod_q[FW +: GW];
					state_q <= S_MODE;
				end
				S_MODE: begin
					k_q  <= gz_q[FW +: IDX_W];
					fz_q <= gz_q[FW-1:0];
					pot_q  <= '0;
					outs_q <= 1'b1;
					if (degen) begin
						state_q <= S_DONE;
					end else if (cyl) begin
						cyl_q <= 1'b1;
						j_q   <= '0;
						fy_q  <= '0;
						u_q   <= u_g[MW-1:0];
						v_q   <= v_g[MW-1:0];
						state_q <= cyl_in ? S_UU : S_DONE;
					end else begin
						cyl_q <= 1'b0;
						i_q   <= gx_q[FW +: IDX_W];
						fx_q  <= gx_q[FW-1:0];
						j_q   <= gy_q[FW +: IDX_W];
						fy_q  <= gy_q[FW-1:0];
						state_q <= (out_x || out_y || out_z) ? S_DONE : S_AD0;
					end
				end
				S_UU: state_q <= S_VV;
				S_VV: begin
					acc_q   <= prod_q[AW-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + prod_q[AW-1:0];
					state_q <= S_SQS;
				end
				S_SQS: state_q <= S_SQ;
				S_SQ: begin
					if (sq_done) begin
						i_q  <= sq_root[FW +: IDX_W];
						fx_q <= sq_root[FW-1:0];
						state_q <= r_in ? S_AD0 : S_DONE;
					end
				end
				S_AD0: state_q <= S_AD1;
				S_AD1: begin
					nxny_q  <= prod_q[DW-1:0];
					state_q <= S_AD2;
				end
				S_AD2: begin
					row_q   <= prod_q[DW-1:0];
					state_q <= S_AD3;
				end
				S_AD3: begin
					base_q  <= DW'(i_q) + row_q + prod_q[DW-1:0];
					cnt_q   <= '0;
					rdv_q   <= 1'b0;
					state_q <= S_RD;
				end
				S_RD: begin
					rdv_q <= !cnt_q[3];
					oob_q <= rd_full >= 32'(GRID_DEPTH);
					if (rdv_q) begin
						for (int n = 0; n < 7; n++) begin
							w_q[n] <= w_q[n+1];
						end
						w_q[7] <= (oob_q || acc_q_in) ? '0 : $signed(rdata_q);
					end
					if (cnt_q[3]) begin
						step_q  <= '0;
						state_q <= S_LA;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_LA: state_q <= S_LB;
				S_LB: begin
					acc_q   <= prod_q[AW-1:0];
					state_q <= S_LC;
				end
				S_LC: begin
					for (int n = 0; n < 6; n++) begin
						w_q[n] <= (3'(n) == 3'd6 - step_q) ? lerp_res : w_q[n+2];
					end
					if (step_q == 3'd0) begin
						w_q[6] <= lerp_res;
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						pot_q   <= lerp_res;
						outs_q  <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LA;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp_ready) begin
						out_q.potential <= pot_q;
						out_q.outside   <= outs_q;
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`ASSERT_ALWAYS(a_outside_zero, clk, arst_n, rsp_valid |-> (!rsp.outside || rsp.potential == '0), "outside result carries nonzero potential")
	`ASSERT_ALWAYS(a_query_holds, clk, arst_n, (req_valid && req_ready && req.req_type == gpti_pkg::REQ_QUERY) |=> !req_ready, "query beat did not block the next beat")
	`ASSERT_NEVER(a_sqrt_done, clk, arst_n, sq_done && state_q != S_SQ, "square root finished outside its wait state")

endmodule

// File: tb/tb_grid_potential_trilinear_interp_top.sv
// ----------------------------------------------------------------------------
// Grid potential interpolator testbench
// Loads node potentials, queries positions in degenerate, 3D and cylindrical
// grids under several register settings and idle patterns, and compares every
// result beat field by field with a behavioral predictor of the interpolation.
// ----------------------------------------------------------------------------
module tb_grid_potential_trilinear_interp_top;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [gpti_pkg::PADDR_W-1:0] paddr = '0;
	logic [gpti_pkg::PDATA_W-1:0] pwdata = '0;
	logic [gpti_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	gpti_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	gpti_pkg::rsp_t rsp;

	grid_potential_trilinear_interp_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #10 clk = ~clk;

	gpti_pkg::req_t beats_to_send[$];
	gpti_pkg::rsp_t potentials_due[$];
	logic signed [31:0] node_mem [int];
	int nx_cfg = 1, ny_cfg = 1, nz_cfg = 1;
	longint unsigned inv_cfg = 655360;
	int idle_mode = IDLE_NONE;
	int errors = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic longint node_at(longint i, longint j, longint k);
		longint unsigned addr;
		addr = i + nx_cfg * (j + ny_cfg * k);
		if (addr >= 262144 || !node_mem.exists(int'(addr)))
			return 0;
		return node_mem[int'(addr)];
	endfunction

	function automatic longint blend(longint a, longint b, longint f);
		return (a * (65536 - f) + b * f + 32768) >>> 16;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic bit off_axis(longint g, longint n);
		return g < 0 || g >= (n - 1) * 65536;
	endfunction

	function automatic gpti_pkg::rsp_t interpolate(gpti_pkg::req_t r);
		gpti_pkg::rsp_t o;
		longint gx, gy, gz, c, u, v, rad, i, j, k, fx, fy, fz, a0, a1, p0, p1, pot;
		bit outside;
		gx = (longint'(r.pos_x) * longint'(inv_cfg)) >>> 16;
		gy = (longint'(r.pos_y) * longint'(inv_cfg)) >>> 16;
		gz = (longint'(r.pos_z) * longint'(inv_cfg)) >>> 16;
		outside = 1'b1;
		pot = 0;
		if (nx_cfg > 64 || ny_cfg > 64 || nz_cfg > 64) begin
			outside = 1'b1;
		end else if (nx_cfg > 2 && ny_cfg == 1 && nz_cfg > 2) begin
			c = (nx_cfg - 1) * 65536;
			u = gx - c;
			v = gy - c;
			if (u > -c && u < c && v > -c && v < c && !off_axis(gz, nz_cfg)) begin
				rad = root_floor(u * u + v * v);
				if (rad < c) begin
					i = rad >>> 16; fx = rad & 16'hFFFF;
					k = gz >>> 16; fz = gz & 16'hFFFF;
					a0 = blend(node_at(i, 0, k), node_at(i + 1, 0, k), fx);
					a1 = blend(node_at(i, 0, k + 1), node_at(i + 1, 0, k + 1), fx);
					pot = blend(a0, a1, fz);
					outside = 1'b0;
				end
			end
		end else if (nx_cfg > 2 || ny_cfg > 2 || nz_cfg > 2) begin
			if (!off_axis(gx, nx_cfg) && !off_axis(gy, ny_cfg) && !off_axis(gz, nz_cfg)) begin
				i = gx >>> 16; fx = gx & 16'hFFFF;
				j = gy >>> 16; fy = gy & 16'hFFFF;
				k = gz >>> 16; fz = gz & 16'hFFFF;
				a0 = blend(node_at(i, j, k), node_at(i + 1, j, k), fx);
				a1 = blend(node_at(i, j + 1, k), node_at(i + 1, j + 1, k), fx);
				p0 = blend(a0, a1, fy);
				a0 = blend(node_at(i, j, k + 1), node_at(i + 1, j, k + 1), fx);
				a1 = blend(node_at(i, j + 1, k + 1), node_at(i + 1, j + 1, k + 1), fx);
				p1 = blend(a0, a1, fy);
				pot = blend(p0, p1, fz);
				outside = 1'b0;
			end
		end
		if (outside)
			pot = 0;
		if (pot > 64'sd2147483647)
			pot = 64'sd2147483647;
		if (pot < -64'sd2147483648)
			pot = -64'sd2147483648;
		o.potential = pot[31:0];
		o.outside = outside;
		return o;
	endfunction

	// driver: predict on the accepted beat, then present the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if (req.req_type == gpti_pkg::REQ_LOAD)
					node_mem[int'(req.node_index)] = req.node_value;
				else
					potentials_due.push_back(interpolate(req));
			end
			if (!req_valid || req_ready) begin
				if (beats_to_send.size() > 0 && !((idle_mode == IDLE_SEND &&
						$urandom_range(99) < 49) || (idle_mode == IDLE_BOTH &&
						$urandom_range(99) < 35))) begin
					req <= beats_to_send.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		gpti_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (potentials_due.size() == 0) begin
					report_mismatch("unexpected beat, potential", rsp.potential, 0);
				end else begin
					want = potentials_due.pop_front();
					if (rsp.potential !== want.potential)
						report_mismatch("potential", rsp.potential, want.potential);
					if (rsp.outside !== want.outside)
						report_mismatch("outside", rsp.outside, want.outside);
				end
			end
			rsp_ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 49) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 35));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= gpti_pkg::PADDR_W'({idx, 2'b00}); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			gpti_pkg::REG_SIZE_X: nx_cfg = int'(val[6:0]);
			gpti_pkg::REG_SIZE_Y: ny_cfg = int'(val[6:0]);
			gpti_pkg::REG_SIZE_Z: nz_cfg = int'(val[6:0]);
			default: inv_cfg = longint'(val);
		endcase
	endtask

	task automatic wait_idle();
		while (beats_to_send.size() > 0 || req_valid || potentials_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int x, input int y, input int z, input logic [31:0] inv);
		wait_idle();
		write_reg(gpti_pkg::REG_SIZE_X, x);
		write_reg(gpti_pkg::REG_SIZE_Y, y);
		write_reg(gpti_pkg::REG_SIZE_Z, z);
		write_reg(gpti_pkg::REG_INV, inv);
	endtask

	function automatic gpti_pkg::req_t load_beat(input int idx, input logic [31:0] val);
		gpti_pkg::req_t b;
		b = '0;
		b.req_type = gpti_pkg::REQ_LOAD;
		b.node_index = idx[gpti_pkg::IDXIN_W-1:0];
		b.node_value = val;
		b.pos_x = $urandom; b.pos_y = $urandom; b.pos_z = $urandom;
		return b;
	endfunction

	// grid units in Q.16 to a position
	function automatic logic [31:0] to_pos(input longint g);
		longint p;
		if (inv_cfg == 0)
			return $urandom;
		p = (g <<< 16) / longint'(inv_cfg);
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return p[31:0];
	endfunction

	function automatic longint pick_coord(input int n);
		return longint'($urandom_range(n * 65536 + 16384)) - 8192;
	endfunction

	function automatic gpti_pkg::req_t query_beat(input longint gx, input longint gy,
			input longint gz);
		gpti_pkg::req_t b;
		b.req_type = gpti_pkg::REQ_QUERY;
		b.node_index = 18'($urandom);
		b.node_value = $urandom;
		b.pos_x = to_pos(gx); b.pos_y = to_pos(gy); b.pos_z = to_pos(gz);
		return b;
	endfunction

	task automatic fill_grid(input bit extremes);
		int n;
		n = nx_cfg * ny_cfg * nz_cfg;
		for (int a = 0; a < n; a++)
			beats_to_send.push_back(load_beat(a, extremes ?
				((a % 2) ? 32'h7FFFFFFF : 32'h80000000) : $urandom));
	endtask

	task automatic random_queries(input int count);
		gpti_pkg::req_t b;
		int n, c;
		n = nx_cfg * ny_cfg * nz_cfg;
		c = nx_cfg - 1;
		for (int q = 0; q < count; q++) begin
			case ($urandom_range(9))
				0: beats_to_send.push_back(load_beat($urandom_range(n - 1), $urandom));
				1: beats_to_send.push_back(load_beat($urandom, $urandom));
				2: begin
					b = query_beat(0, 0, 0);
					b.pos_x = $urandom; b.pos_y = $urandom; b.pos_z = $urandom;
					beats_to_send.push_back(b);
				end
				default: begin
					if (ny_cfg == 1 && nx_cfg > 2)
						beats_to_send.push_back(query_beat(pick_coord(2 * c + 1),
							pick_coord(2 * c + 1), pick_coord(nz_cfg - 1)));
					else
						beats_to_send.push_back(query_beat(pick_coord(nx_cfg - 1),
							pick_coord(ny_cfg - 1), pick_coord(nz_cfg - 1)));
				end
			endcase
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: degenerate grid
		beats_to_send.push_back(query_beat(0, 0, 0));
		beats_to_send.push_back(query_beat(-64'sd1 <<< 40, 64'sd1 <<< 40, 64'sd65536));

		configure(4, 3, 5, 32'd65536);
		fill_grid(1'b1);
		beats_to_send.push_back(query_beat(0, 0, 0));
		beats_to_send.push_back(query_beat(3 * 65536 - 1, 2 * 65536 - 1, 4 * 65536 - 1));
		beats_to_send.push_back(query_beat(3 * 65536, 0, 0));
		beats_to_send.push_back(query_beat(0, -1, 0));
		beats_to_send.push_back(query_beat(32768, 32768, 32768));
		beats_to_send.push_back(query_beat(65535, 1, 98304));
		begin
			gpti_pkg::req_t b;
			b = query_beat(0, 0, 0);
			b.pos_x = 32'h7FFFFFFF; b.pos_y = 32'h80000000; b.pos_z = 32'h80000000;
			beats_to_send.push_back(b);
		end
		fill_grid(1'b0);
		random_queries(80);

		idle_mode = IDLE_SEND;
		configure(8, 1, 6, 32'd65536);
		fill_grid(1'b0);
		beats_to_send.push_back(query_beat(7 * 65536, 7 * 65536, 65536));
		beats_to_send.push_back(query_beat(0, 7 * 65536, 65536));
		beats_to_send.push_back(query_beat(7 * 65536, 14 * 65536 - 1, 0));
		random_queries(200);

		idle_mode = IDLE_RECV;
		configure(64, 1, 3, 32'd163840);
		fill_grid(1'b0);
		random_queries(100);

		idle_mode = IDLE_BOTH;
		configure(2, 2, 3, 32'hFFFFFFFF);
		fill_grid(1'b0);
		random_queries(150);

		idle_mode = IDLE_NONE;
		configure(3, 64, 2, 32'd30000);
		fill_grid(1'b0);
		random_queries(60);

		idle_mode = IDLE_SEND;
		configure(5, 4, 3, 32'd0);
		fill_grid(1'b0);
		random_queries(60);

		idle_mode = IDLE_RECV;
		configure(100, 3, 3, 32'd65536);
		random_queries(40);
		configure(2, 2, 2, 32'd65536);
		random_queries(30);
		configure(1, 5, 5, 32'd1);
		random_queries(40);

		idle_mode = IDLE_BOTH;
		configure(6, 6, 6, 32'd65536);
		fill_grid(1'b0);
		random_queries(60);

		idle_mode = IDLE_NONE;
		configure(5, 1, 4, 32'd98304);
		fill_grid(1'b0);
		random_queries(60);

		wait_idle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
